@@ rtl/lknp_pkg.sv @@
package lknp_pkg;

	// byte values the parser reacts to
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	// key that selects a value for parsing
	localparam int unsigned KEY_LEN = 7;
	localparam logic [7:0] CHAR_L     = 8'h4C;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_Y     = 8'h59;
	localparam logic [7:0] CHAR_E     = 8'h45;
	localparam logic [7:0] CHAR_R     = 8'h52;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	// result codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NO_DIGIT = 2'd1;
	localparam logic [1:0] ERR_RANGE    = 2'd2;

	// int range limits on the magnitude
	localparam logic [35:0] MAG_NEG_LIMIT = 36'h0_8000_0000;
	localparam logic [31:0] MAG_POS_LIMIT = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		PH_MATCH,
		PH_SKIPKEY,
		PH_SKIPVAL,
		PH_PARSE
	} parse_phase_t;

	typedef enum logic [1:0] {
		NP_SPACE,
		NP_SIGN,
		NP_DIGITS,
		NP_TAIL
	} number_phase_t;

	// byte handed from the key matcher to the number parser
	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
		logic       in_value;
	} token_t;

	typedef struct packed {
		logic [31:0] layer_number;
		logic [1:0]  error_code;
	} result_t;

	// character of the key at a position
	function automatic logic [7:0] key_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = CHAR_L;
			3'd1: c = CHAR_A;
			3'd2: c = CHAR_Y;
			3'd3: c = CHAR_E;
			3'd4: c = CHAR_R;
			3'd5: c = CHAR_COLON;
			3'd6: c = CHAR_COLON;
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/lknp_fifo.sv @@
module lknp_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             wr_en;
	logic             rd_en;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign wr_en   = push && !full;
	assign rd_en   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

@@ rtl/lknp_front.sv @@
module lknp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     byte_value,
	input  logic           last_byte,
	output logic           tok_push,
	output lknp_pkg::token_t tok
);
	import lknp_pkg::*;

	parse_phase_t phase_q, phase_d;
	logic [2:0]   match_count_q, match_count_d;

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_MATCH;
			match_count_q <= 3'd0;
		end else if (accept) begin
			phase_q       <= phase_d;
			match_count_q <= match_count_d;
		end
	end

	// key matching and pair skipping
	always_comb begin
		phase_d       = phase_q;
		match_count_d = match_count_q;
		unique case (phase_q)
			PH_MATCH: begin
				if (match_count_q != 3'(KEY_LEN) && byte_value == key_char(match_count_q)) begin
					match_count_d = match_count_q + 3'd1;
				end else if (match_count_q == 3'(KEY_LEN) && byte_value == CHAR_NUL) begin
					phase_d       = PH_PARSE;
					match_count_d = 3'd0;
				end else begin
					phase_d       = (byte_value == CHAR_NUL) ? PH_SKIPVAL : PH_SKIPKEY;
					match_count_d = 3'd0;
				end
			end
			PH_SKIPKEY: begin
				if (byte_value == CHAR_NUL) begin
					phase_d = PH_SKIPVAL;
				end
			end
			PH_SKIPVAL: begin
				if (byte_value == CHAR_NUL) begin
					phase_d = PH_MATCH;
				end
			end
			PH_PARSE: begin
				if (byte_value == CHAR_NUL) begin
					phase_d = PH_MATCH;
				end
			end
			default: begin
				phase_d = PH_MATCH;
			end
		endcase
		if (last_byte) begin
			phase_d       = PH_MATCH;
			match_count_d = 3'd0;
		end
	end

	// value bytes and end of stream go on to the number parser
	assign tok.byte_value = byte_value;
	assign tok.last_byte  = last_byte;
	assign tok.in_value   = (phase_q == PH_PARSE);
	assign tok_push       = accept && ((phase_q == PH_PARSE) || last_byte);
endmodule

@@ rtl/lknp_back.sv @@
module lknp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  lknp_pkg::token_t  tok,
	output logic              tok_pop,
	input  logic              res_full,
	output logic              res_push,
	output lknp_pkg::result_t res
);
	import lknp_pkg::*;

	typedef struct packed {
		number_phase_t phase;
		logic [31:0]   magnitude;
		logic          negative_sign;
		logic          digit_seen;
		logic          overflowed;
		logic          field_started;
	} field_t;

	localparam field_t FIELD_CLEAR = '{NP_SPACE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0};

	field_t  field_q, field_d, upd;
	logic    discard_q, discard_d;
	logic    dig;
	logic    space;
	logic    sign;
	logic [35:0] prod;
	result_t fin;
	logic    fin_err;

	assign tok_pop = tok_valid && !res_full;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q   <= FIELD_CLEAR;
			discard_q <= 1'b0;
		end else if (tok_pop) begin
			field_q   <= field_d;
			discard_q <= discard_d;
		end
	end

	// byte classes
	assign dig   = (tok.byte_value >= CHAR_ZERO) && (tok.byte_value <= CHAR_NINE);
	assign space = (tok.byte_value == CHAR_SPACE) ||
		((tok.byte_value >= CHAR_TAB) && (tok.byte_value <= CHAR_CR));
	assign sign  = (tok.byte_value == CHAR_PLUS) || (tok.byte_value == CHAR_MINUS);

	// times ten plus digit
	assign prod = ({4'd0, field_q.magnitude} << 3) + ({4'd0, field_q.magnitude} << 1) +
		{32'd0, tok.byte_value[3:0]};

	// one byte of a number field
	always_comb begin
		upd               = field_q;
		upd.field_started = 1'b1;
		unique case (field_q.phase)
			NP_SPACE: begin
				if (sign) begin
					upd.negative_sign = (tok.byte_value == CHAR_MINUS);
					upd.phase         = NP_SIGN;
				end else if (!space && !dig) begin
					upd.phase = NP_TAIL;
				end
			end
			NP_SIGN, NP_DIGITS: begin
				if (!dig) begin
					upd.phase = NP_TAIL;
				end
			end
			NP_TAIL: begin
			end
			default: begin
				upd.phase = NP_TAIL;
			end
		endcase
		if (dig && field_q.phase != NP_TAIL) begin
			upd.phase      = NP_DIGITS;
			upd.digit_seen = 1'b1;
			if (field_q.overflowed || prod > MAG_NEG_LIMIT) begin
				upd.overflowed = 1'b1;
			end else begin
				upd.magnitude = prod[31:0];
			end
		end
	end

	// finish a field: from the updated field on a plain byte, else the stored one
	always_comb begin
		field_t f;
		f = (tok.byte_value == CHAR_NUL || tok.byte_value == CHAR_COMMA) ? field_q : upd;
		fin_err = 1'b1;
		fin.layer_number = 32'd0;
		if (!f.digit_seen) begin
			fin.error_code = ERR_NO_DIGIT;
		end else if (f.overflowed || (!f.negative_sign && f.magnitude > MAG_POS_LIMIT)) begin
			fin.error_code = ERR_RANGE;
		end else begin
			fin_err          = 1'b0;
			fin.error_code   = ERR_NONE;
			fin.layer_number = f.negative_sign ? (32'd0 - f.magnitude) : f.magnitude;
		end
	end

	// transaction handling
	always_comb begin
		field_d   = field_q;
		discard_d = discard_q;
		res_push  = 1'b0;
		res       = fin;
		if (!discard_q && tok.in_value) begin
			priority if (tok.byte_value == CHAR_NUL) begin
				if (field_q.field_started) begin
					res_push  = tok_pop;
					discard_d = fin_err;
				end
				field_d = FIELD_CLEAR;
			end else if (tok.byte_value == CHAR_COMMA) begin
				res_push  = tok_pop;
				discard_d = fin_err;
				field_d   = FIELD_CLEAR;
			end else begin
				if (tok.last_byte) begin
					res_push = tok_pop;
					field_d  = FIELD_CLEAR;
				end else begin
					field_d = upd;
				end
			end
		end
		// end of stream starts afresh
		if (tok.last_byte) begin
			field_d   = FIELD_CLEAR;
			discard_d = 1'b0;
		end
	end
endmodule

@@ rtl/layer_key_number_list_parser.sv @@
// Layer-number list parser.
// Input side is a queue: drive byte_value and last_byte, raise push; a
// transaction happens at a clock edge with push high and full low. The stream
// is alternating NUL-terminated keys and values; last_byte marks its end.
// Output side is a queue: while empty is low, layer_number and error_code
// carry the oldest result; raising pop takes it at that edge.
// Only values under the key "LAYER::" yield results: one per comma-separated
// number, error_code 1 for a field without digits, 2 for a value outside the
// int range. After an error the rest of the stream is dropped.
// Throughput is one byte per cycle while full stays low. A front stage
// matches keys and forwards value bytes through a two-entry queue to the
// number accumulator, whose multiply-by-ten add is the critical step;
// results pass through a two-entry output queue. The byte that ends a field
// is registered in the inner queue, its result then in the output queue.
// When pop is held low the output queue fills, the accumulator stops and the
// inner queue then raises full; no transaction is lost.
// Asynchronous reset (arst_n low) empties both queues and restarts key
// matching at the start of a stream.
module layer_key_number_list_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic        push,
	output logic        full,
	output logic [31:0] layer_number,
	output logic [1:0]  error_code,
	output logic        empty,
	input  logic        pop
);
	import lknp_pkg::*;

	token_t  tok_in, tok_out;
	logic    tok_push;
	logic    tok_full;
	logic    tok_empty;
	logic    tok_pop;
	result_t res_in, res_out;
	logic    res_push;
	logic    res_full;

	assign full = tok_full;

	// key matching front
	lknp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (push && !tok_full),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.tok_push   (tok_push),
		.tok        (tok_in)
	);

	// queue between front and number parser
	lknp_fifo #(
		.WIDTH ($bits(token_t))
	) u_tok_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (tok_push),
		.wr_data (tok_in),
		.full    (tok_full),
		.pop     (tok_pop),
		.rd_data (tok_out),
		.empty   (tok_empty)
	);

	// number parser
	lknp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (!tok_empty),
		.tok       (tok_out),
		.tok_pop   (tok_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue
	lknp_fifo #(
		.WIDTH ($bits(result_t))
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign layer_number = res_out.layer_number;
	assign error_code   = res_out.error_code;
endmodule

@@ sim/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lknp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_BYTES = 660;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned ROWS         = 16;

	// key text, first character in the top byte
	localparam logic [55:0] LAYER_KEY = {CHAR_L, CHAR_A, CHAR_Y, CHAR_E, CHAR_R,
		CHAR_COLON, CHAR_COLON};

	// scan phases of the byte stream
	typedef enum logic [2:0] {
		SCAN_KEY,
		SCAN_SKIP_KEY,
		SCAN_SKIP_VALUE,
		SCAN_LIST,
		SCAN_DROP
	} scan_phase_t;

	// directed row expectation: typed marks a result read off by hand
	typedef struct packed {
		bit      typed;
		result_t res;
	} row_expect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  byte_value = 8'h00;
	logic        last_byte = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] layer_number;
	logic [1:0]  error_code;
	logic        empty;
	logic        pop = 1'b0;

	// predictor state
	scan_phase_t   scan;
	int unsigned   key_pos;
	number_phase_t num_phase;
	logic [31:0]   mag_acc;
	bit            neg_seen;
	bit            dig_seen;
	bit            too_big;
	bit            field_open;

	result_t       layer_results_due[$];
	logic [7:0]    stream_bytes[$];
	int unsigned   mismatches = 0;
	int unsigned   results_seen = 0;
	int unsigned   cycle_count = 0;
	bit            typed_row = 0;
	bit            sender_calm = 0;
	bit            hold_req = 0;
	bit            hold_done = 0;
	int unsigned   hold_left = 0;
	int unsigned   stall_left = 0;
	int unsigned   calm_left = 0;

	// directed streams, '|' stands for a NUL byte; the last character ends the stream
	string row_text [ROWS] = '{
		"LAYER::|7",
		"LAYER::|-2147483648|",
		"LAYER::|+2147483647|",
		"LAYER::|2147483648|",
		"LAYER::|-2147483649|",
		"LAYER::|99999999999|",
		"LAYER::|,5|",
		"LAYER::| -|",
		"LAYER::|x7|",
		"LAYER::| \011\012\013\014\01512abc,0034,-0|",
		"LAYER::||KEY|val|LAYER::|3,|",
		"LAYER:|5||6|LAYER::X|7|LAYER::|8|",
		"LAYE",
		"LAYER::|4,",
		"LAYER::|\3779,\2005|",
		"LAYER::|0|"
	};

	row_expect_t row_expect [ROWS] = '{
		{1'b1, 32'd7,          ERR_NONE},
		{1'b1, 32'h8000_0000,  ERR_NONE},
		{1'b1, 32'h7FFF_FFFF,  ERR_NONE},
		{1'b1, 32'd0,          ERR_RANGE},
		{1'b1, 32'd0,          ERR_RANGE},
		{1'b1, 32'd0,          ERR_RANGE},
		{1'b1, 32'd0,          ERR_NO_DIGIT},
		{1'b1, 32'd0,          ERR_NO_DIGIT},
		{1'b1, 32'd0,          ERR_NO_DIGIT},
		{1'b0, 32'd0,          ERR_NONE},
		{1'b0, 32'd0,          ERR_NONE},
		{1'b0, 32'd0,          ERR_NONE},
		{1'b0, 32'd0,          ERR_NONE},
		{1'b0, 32'd0,          ERR_NONE},
		{1'b0, 32'd0,          ERR_NONE},
		{1'b1, 32'd0,          ERR_NONE}
	};

	layer_key_number_list_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.push         (push),
		.full         (full),
		.layer_number (layer_number),
		.error_code   (error_code),
		.empty        (empty),
		.pop          (pop)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_number();
		num_phase  = NP_SPACE;
		mag_acc    = '0;
		neg_seen   = 0;
		dig_seen   = 0;
		too_big    = 0;
		field_open = 0;
	endfunction

	function automatic void restart_scan();
		scan    = SCAN_KEY;
		key_pos = 0;
		clear_number();
	endfunction

	// closes the open field, returns 1 on an error result
	function automatic bit close_field(output result_t res);
		bit bad;
		res.layer_number = '0;
		if (!dig_seen) begin
			res.error_code = ERR_NO_DIGIT;
		end else if (too_big || (!neg_seen && mag_acc > MAG_POS_LIMIT)) begin
			res.error_code = ERR_RANGE;
		end else begin
			res.error_code   = ERR_NONE;
			res.layer_number = neg_seen ? (32'd0 - mag_acc) : mag_acc;
		end
		bad = (res.error_code != ERR_NONE);
		clear_number();
		return bad;
	endfunction

	// one byte of a field: whitespace, sign, digits, then ignored tail
	function automatic void number_char(input logic [7:0] b);
		bit          is_digit;
		bit          is_blank;
		logic [63:0] next_mag;
		is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		is_blank   = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
		field_open = 1;
		if (num_phase == NP_SPACE && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
			neg_seen  = (b == CHAR_MINUS);
			num_phase = NP_SIGN;
		end else begin
			if (!is_digit && !(num_phase == NP_SPACE && is_blank))
				num_phase = NP_TAIL;
			if (is_digit && num_phase != NP_TAIL) begin
				next_mag  = {32'd0, mag_acc} * 64'd10 + 64'(b - CHAR_ZERO);
				num_phase = NP_DIGITS;
				dig_seen  = 1;
				if (too_big || next_mag > 64'(MAG_NEG_LIMIT))
					too_big = 1;
				else
					mag_acc = next_mag[31:0];
			end
		end
	endfunction

	// advances the predictor by one accepted byte, returns 1 when a result is due
	function automatic bit layer_predict(input logic [7:0] b, input bit last,
			output result_t res);
		bit got;
		got = 0;
		res = '0;
		case (scan)
			SCAN_KEY: begin
				if (key_pos < KEY_LEN && b == LAYER_KEY[55 - 8 * key_pos -: 8]) begin
					key_pos++;
				end else if (key_pos >= KEY_LEN && b == CHAR_NUL) begin
					scan    = SCAN_LIST;
					key_pos = 0;
					clear_number();
				end else begin
					scan    = (b == CHAR_NUL) ? SCAN_SKIP_VALUE : SCAN_SKIP_KEY;
					key_pos = 0;
				end
			end
			SCAN_SKIP_KEY: begin
				if (b == CHAR_NUL)
					scan = SCAN_SKIP_VALUE;
			end
			SCAN_SKIP_VALUE: begin
				if (b == CHAR_NUL)
					scan = SCAN_KEY;
			end
			SCAN_LIST: begin
				if (b == CHAR_NUL) begin
					if (field_open) begin
						got  = 1;
						scan = close_field(res) ? SCAN_DROP : SCAN_KEY;
					end else begin
						clear_number();
						scan = SCAN_KEY;
					end
				end else if (b == CHAR_COMMA) begin
					got = 1;
					if (close_field(res))
						scan = SCAN_DROP;
				end else begin
					number_char(b);
					if (last) begin
						got = 1;
						void'(close_field(res));
					end
				end
			end
			default: begin
			end
		endcase
		if (last)
			restart_scan();
		return got;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// any byte that neither ends a field nor a value
	function automatic logic [7:0] junk_char();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == CHAR_NUL || b == CHAR_COMMA);
		return b;
	endfunction

	// appends one byte to the stream being built
	task automatic add_byte(input logic [7:0] b);
		stream_bytes.insert(stream_bytes.size(), b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// one list field with random whitespace, sign, magnitude and tail
	task automatic add_number_field();
		int unsigned r;
		logic [63:0] mag;
		bit          no_digits;
		mag       = '0;
		no_digits = 0;
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2))
				add_byte(($urandom_range(0, 5) == 0) ? CHAR_SPACE :
					8'(CHAR_TAB + $urandom_range(0, 4)));
		r = $urandom_range(0, 9);
		if (r < 3)
			add_byte(CHAR_MINUS);
		else if (r == 3)
			add_byte(CHAR_PLUS);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			mag = $urandom_range(0, 999);
		end else if (r < 62) begin
			mag = 64'($urandom >> $urandom_range(0, 31));
		end else if (r < 74) begin
			mag = 64'd2147483638 + 64'($urandom_range(0, 20));
		end else if (r < 80) begin
			mag = {$urandom, $urandom} >> $urandom_range(0, 40);
		end else if (r < 85) begin
			no_digits = 1;
		end else begin
			add_text("000");
			mag = $urandom_range(0, 99);
		end
		if (!no_digits)
			add_text($sformatf("%0d", mag));
		if ($urandom_range(0, 6) == 0)
			repeat ($urandom_range(1, 3))
				add_byte(junk_char());
	endtask

	// matching key followed by a list of zero to four fields
	task automatic add_layer_pair();
		int unsigned n;
		add_text("LAYER::");
		add_byte(CHAR_NUL);
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				add_byte(CHAR_COMMA);
			add_number_field();
		end
		if ($urandom_range(0, 19) == 0)
			add_byte(CHAR_COMMA);
		add_byte(CHAR_NUL);
	endtask

	// pair whose key misses, often narrowly
	task automatic add_other_pair();
		int unsigned len;
		string       key_txt;
		key_txt = "LAYER::";
		case ($urandom_range(0, 3))
			0: begin
				len = $urandom_range(0, 6);
				if (len != 0)
					add_text(key_txt.substr(0, len - 1));
			end
			1: begin
				add_text(key_txt);
				add_byte(junk_char());
			end
			2: repeat ($urandom_range(1, 6))
				add_byte(8'($urandom_range(33, 126)));
			default: repeat ($urandom_range(1, 4))
				add_byte(8'($urandom_range(1, 255)));
		endcase
		add_byte(CHAR_NUL);
		repeat ($urandom_range(0, 5))
			add_byte(8'($urandom_range(1, 255)));
		add_byte(CHAR_NUL);
	endtask

	// offers one byte and waits for its transaction
	task automatic send_byte(input logic [7:0] b, input bit last);
		int unsigned gap;
		bit          got;
		result_t     res;
		gap = sender_calm ? 0 : idle_len();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		byte_value <= b;
		last_byte  <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		got = layer_predict(b, last, res);
		if (got && !typed_row)
			layer_results_due.insert(layer_results_due.size(), res);
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
	endtask

	// ---------------------------------------------------------------- sender

	initial begin
		int unsigned bytes_sent;
		int unsigned keep;
		restart_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int r = 0; r < ROWS; r++) begin
			stream_bytes.delete();
			for (int i = 0; i < row_text[r].len(); i++)
				add_byte((row_text[r][i] == "|") ? CHAR_NUL : row_text[r][i]);
			typed_row = row_expect[r].typed;
			if (typed_row)
				layer_results_due.insert(layer_results_due.size(), row_expect[r].res);
			sender_calm = ($urandom_range(0, 3) == 0);
			send_stream();
		end
		typed_row = 0;

		// random streams
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			stream_bytes.delete();
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 12))
					add_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 3))
					if ($urandom_range(0, 9) < 7)
						add_layer_pair();
					else
						add_other_pair();
			end
			if ($urandom_range(0, 6) == 0) begin
				keep = $urandom_range(1, stream_bytes.size());
				while (stream_bytes.size() > keep)
					void'(stream_bytes.pop_back());
			end
			if (bytes_sent >= 300 && !hold_req)
				hold_req = 1;
			sender_calm = (hold_left != 0) || (hold_req && !hold_done) ||
				($urandom_range(0, 4) == 0);
			send_stream();
			bytes_sent += stream_bytes.size();
		end
		push <= 1'b0;

		// drain
		while (layer_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("layer_key_number_list_parser: match");
		else
			$display("layer_key_number_list_parser: mismatch");
		$finish;
	end

	// ---------------------------------------------------------------- receiver

	// pop pattern: random stalls, calm stretches, one long hold-off
	always @(posedge clk) begin
		int unsigned n;
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_done) begin
			pop <= 1'b0;
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end else if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left--;
		end else if (calm_left != 0) begin
			pop <= 1'b1;
			calm_left--;
		end else begin
			n = idle_len();
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(50, 200);
			if (n == 0) begin
				pop <= 1'b1;
			end else begin
				pop <= 1'b0;
				stall_left = n - 1;
			end
		end
	end

	// ---------------------------------------------------------------- result check

	task automatic report_bad(input string what, input result_t want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("result %0d %s: expected %h code %0d, got %h code %0d",
				results_seen, what, want.layer_number, want.error_code,
				layer_number, error_code);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (layer_results_due.size() == 0) begin
				report_bad("unexpected", '0);
			end else begin
				want = layer_results_due.pop_front();
				if (layer_number !== want.layer_number || error_code !== want.error_code)
					report_bad("wrong", want);
			end
			results_seen++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("layer_key_number_list_parser: mismatch");
			$finish;
		end
	end

endmodule

@@ sim.f @@
rtl/lknp_pkg.sv
rtl/lknp_fifo.sv
rtl/lknp_front.sv
rtl/lknp_back.sv
rtl/layer_key_number_list_parser.sv
sim/tb_top.sv
